// ----- src/qstp_pkg.sv -----
`default_nettype none

package qstp_pkg;

  // Four quaternion components, one lane each.
  localparam int NUM_LANES = 4;

  // Seven trial bits give the byte offset from the midpoint (0..127).
  localparam int SEARCH_STEPS = 7;

  // Pipeline depth: magnitude/square, sum/scale, search steps, output.
  localparam int NUM_STAGES = SEARCH_STEPS + 3;

  // The scale 255^2 = 65025 = 2^16 - 2^9 + 1, applied as shifts and adds.
  localparam int SCALE_SHIFT_HI = 16;
  localparam int SCALE_SHIFT_LO = 9;

  // Tag byte base and the byte midpoint.
  localparam logic [7:0] TAG_BASE  = 8'd252;
  localparam logic [7:0] CODE_MID  = 8'd128;

  typedef logic [1:0] lane_idx_t;
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // What one lane found at the end of its search.
  typedef struct packed {
    logic [SEARCH_STEPS-1:0] k;
    logic                    exact;
    logic                    neg;
  } lane_res_t;

  // What the merge stage found over all lanes.
  typedef struct packed {
    lane_idx_t big;
    logic      zero;
  } merge_res_t;

endpackage

`default_nettype wire

// ----- src/qstp_in_if.sv -----
`default_nettype none

interface qstp_in_if #(
  parameter int COMPONENT_BITS = 16
) ();
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] part_a;
  logic signed [COMPONENT_BITS-1:0] part_b;
  logic signed [COMPONENT_BITS-1:0] part_c;
  logic signed [COMPONENT_BITS-1:0] part_d;

  modport source (output valid, output part_a, output part_b, output part_c,
                  output part_d, input ready);
  modport sink (input valid, input part_a, input part_b, input part_c,
                input part_d, output ready);
endinterface

`default_nettype wire

// ----- src/qstp_out_if.sv -----
`default_nettype none

interface qstp_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] code_first;
  logic [7:0] code_second;
  logic [7:0] code_third;
  logic [7:0] tag_byte;
  logic       valid_res;

  modport source (output valid, output code_first, output code_second,
                  output code_third, output tag_byte, output valid_res, input ready);
  modport sink (input valid, input code_first, input code_second,
                input code_third, input tag_byte, input valid_res, output ready);
endinterface

`default_nettype wire

// ----- src/qstp_lane.sv -----
`default_nettype none

module qstp_lane #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic                            clk,
  input  wire qstp_pkg::stage_en_t             en,
  input  wire logic [COMPONENT_BITS-1:0]       comp,
  input  wire logic [2*COMPONENT_BITS:0]       sum,
  output logic      [COMPONENT_BITS-1:0]       mag,
  output logic      [2*COMPONENT_BITS-1:0]     sq,
  output qstp_pkg::lane_res_t                  res
);

  localparam int SW = 2 * COMPONENT_BITS + 1;
  localparam int W  = 2 * COMPONENT_BITS + 18;
  localparam int NS = qstp_pkg::SEARCH_STEPS;

  logic [COMPONENT_BITS-1:0] mag0;
  logic           neg0;
  logic [W-1:0]   r1;
  logic           neg1;

  // Magnitude at the component width, so the most negative value maps to 2^(N-1).
  assign mag0 = comp[COMPONENT_BITS-1] ? (~comp + 1'b1) : comp;

  // Stage 0: magnitude, sign and square of the component.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg0 <= comp[COMPONENT_BITS-1];
      mag  <= mag0;
      sq   <= mag0 * mag0;
    end
  end

  // Stage 1: right-hand side 65025 * q^2 by shifts and adds.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      r1   <= (W'(sq) << qstp_pkg::SCALE_SHIFT_HI) - (W'(sq) << qstp_pkg::SCALE_SHIFT_LO)
            + W'(sq);
      neg1 <= neg0;
    end
  end

  // Search registers: P = 2*S*k^2, Q = 2*S*k, one set per step.
  logic [W-1:0]  p   [1:NS];
  logic [W-1:0]  q   [1:NS];
  logic [W-1:0]  r   [1:NS];
  logic [SW-1:0] s   [1:NS];
  logic [NS-1:0] k   [1:NS];
  logic          n   [1:NS];

  // One trial bit per step, from the top bit down: accept it while
  // 2*S*(k+b)^2 stays at or below 65025*q^2.
  for (genvar t = 0; t < NS; t++) begin : g_step
    localparam int BB = NS - 1 - t;
    logic [W-1:0]  p_in;
    logic [W-1:0]  q_in;
    logic [W-1:0]  r_in;
    logic [SW-1:0] s_in;
    logic [NS-1:0] k_in;
    logic          n_in;
    logic [W-1:0]  trial;

    if (t == 0) begin : g_first
      assign p_in = '0;
      assign q_in = '0;
      assign r_in = r1;
      assign s_in = sum;
      assign k_in = '0;
      assign n_in = neg1;
    end else begin : g_rest
      assign p_in = p[t];
      assign q_in = q[t];
      assign r_in = r[t];
      assign s_in = s[t];
      assign k_in = k[t];
      assign n_in = n[t];
    end

    assign trial = p_in + (q_in << (BB + 1)) + (W'(s_in) << (2 * BB + 1));

    always_ff @(posedge clk) begin
      if (en[t+2]) begin
        r[t+1] <= r_in;
        s[t+1] <= s_in;
        n[t+1] <= n_in;
        if (trial <= r_in) begin
          p[t+1] <= trial;
          q[t+1] <= q_in + (W'(s_in) << (BB + 1));
          k[t+1] <= k_in | (NS'(1) << BB);
        end else begin
          p[t+1] <= p_in;
          q[t+1] <= q_in;
          k[t+1] <= k_in;
        end
      end
    end
  end

  assign res.k     = k[NS];
  assign res.exact = (p[NS] == r[NS]);
  assign res.neg   = n[NS];

endmodule

`default_nettype wire

// ----- src/qstp_merge.sv -----
`default_nettype none

module qstp_merge #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [COMPONENT_BITS-1:0]   mag [qstp_pkg::NUM_LANES],
  input  wire logic [2*COMPONENT_BITS-1:0] sq  [qstp_pkg::NUM_LANES],
  output logic      [2*COMPONENT_BITS:0]   sum,
  output qstp_pkg::merge_res_t             mrg
);

  localparam int SW = 2 * COMPONENT_BITS + 1;

  qstp_pkg::lane_idx_t big_next;
  logic                zero_next;

  // Largest magnitude, first index on ties.
  always_comb begin
    big_next  = '0;
    zero_next = 1'b1;
    for (int i = 0; i < qstp_pkg::NUM_LANES; i++) begin
      if (mag[i] > mag[big_next]) begin
        big_next = qstp_pkg::lane_idx_t'(i);
      end
      if (mag[i] != '0) begin
        zero_next = 1'b0;
      end
    end
  end

  // Squared length and the winner, registered together.
  always_ff @(posedge clk) begin
    if (en) begin
      sum      <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]) + SW'(sq[3]);
      mrg.big  <= big_next;
      mrg.zero <= zero_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/quaternion_smallest_three_packer.sv -----
// Smallest-three quaternion packer.
// The in_item channel carries four signed components of a rotation quaternion
// at any common scale. The out_item channel returns one transaction per input:
// three bytes for the components that are not the largest, in ascending index
// order, a tag byte of 252 plus the index of the largest, and valid_res, which
// is low for an all-zero quaternion (bytes zero, tag 252).
// Each accepted item passes through ten register stages: one for magnitude and
// square, one for length and scale, seven search steps (one byte bit each, in
// four parallel lanes) and the output register.
// Throughput is one transaction per cycle while the receiver accepts; each stage
// holds an item and moves on as soon as the stage after it is free.
// When the receiver stalls, items close the gaps in the pipeline; in_item.ready
// falls only once every stage holds an item.
// Reset (rst, synchronous) empties the pipeline; nothing else needs clearing.
`default_nettype none

module quaternion_smallest_three_packer #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  qstp_in_if.sink   in_item,
  qstp_out_if.source out_item
);

  localparam int NST = qstp_pkg::NUM_STAGES;
  localparam int NL  = qstp_pkg::NUM_LANES;

  logic [NST-1:0]        v;
  qstp_pkg::stage_en_t   en;

  // Stage enables: a stage loads when it is empty or its item moves on.
  always_comb begin
    en[NST-1] = !v[NST-1] || out_item.ready;
    for (int j = NST - 2; j >= 0; j--) begin
      en[j] = !v[j] || en[j+1];
    end
  end

  assign in_item.ready = en[0];

  // Occupancy of each stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_item.valid;
      end
      for (int j = 1; j < NST; j++) begin
        if (en[j]) begin
          v[j] <= v[j-1];
        end
      end
    end
  end

  logic [COMPONENT_BITS-1:0]   comp [NL];
  logic [COMPONENT_BITS-1:0]   mag  [NL];
  logic [2*COMPONENT_BITS-1:0] sq   [NL];
  logic [2*COMPONENT_BITS:0]   sum;
  qstp_pkg::lane_res_t         res  [NL];
  qstp_pkg::merge_res_t        mrg  [1:NST-2];

  assign comp[0] = in_item.part_a;
  assign comp[1] = in_item.part_b;
  assign comp[2] = in_item.part_c;
  assign comp[3] = in_item.part_d;

  // One lane per component.
  for (genvar i = 0; i < NL; i++) begin : g_lane
    qstp_lane #(.COMPONENT_BITS(COMPONENT_BITS)) u_lane (
      .clk  (clk),
      .en   (en),
      .comp (comp[i]),
      .sum  (sum),
      .mag  (mag[i]),
      .sq   (sq[i]),
      .res  (res[i])
    );
  end

  qstp_merge #(.COMPONENT_BITS(COMPONENT_BITS)) u_merge (
    .clk (clk),
    .en  (en[1]),
    .mag (mag),
    .sq  (sq),
    .sum (sum),
    .mrg (mrg[1])
  );

  // Carry the winner alongside the search steps.
  for (genvar j = 2; j <= NST - 2; j++) begin : g_mrg
    always_ff @(posedge clk) begin
      if (en[j]) begin
        mrg[j] <= mrg[j-1];
      end
    end
  end

  // Byte of each lane, relative to the sign of the largest component.
  logic [7:0] code [NL];
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      if (res[i].neg != res[mrg[NST-2].big].neg) begin
        code[i] = qstp_pkg::CODE_MID - {1'b0, res[i].k} - {7'b0, !res[i].exact};
      end else begin
        code[i] = qstp_pkg::CODE_MID + {1'b0, res[i].k};
      end
    end
  end

  // Output register: drop the largest lane and keep index order.
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      if (mrg[NST-2].zero) begin
        out_item.code_first  <= '0;
        out_item.code_second <= '0;
        out_item.code_third  <= '0;
        out_item.valid_res   <= 1'b0;
      end else begin
        out_item.code_first  <= (mrg[NST-2].big == 2'd0) ? code[1] : code[0];
        out_item.code_second <= (mrg[NST-2].big <= 2'd1) ? code[2] : code[1];
        out_item.code_third  <= (mrg[NST-2].big == 2'd3) ? code[2] : code[3];
        out_item.valid_res   <= 1'b1;
      end
      out_item.tag_byte <= qstp_pkg::TAG_BASE + {6'b0, mrg[NST-2].big};
    end
  end

  assign out_item.valid = v[NST-1];

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_item.valid && !out_item.valid_res |->
      out_item.code_first == '0 && out_item.code_second == '0 &&
      out_item.code_third == '0 && out_item.tag_byte == qstp_pkg::TAG_BASE)
    else $error("zero quaternion result is not cleared");

  a_tag_range: assert property (@(posedge clk) disable iff (rst)
    out_item.valid |-> out_item.tag_byte[7:2] == qstp_pkg::TAG_BASE[7:2])
    else $error("tag byte out of range");

  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    !v[0] |-> in_item.ready)
    else $error("input stalled with an empty first stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    v[NST-1] && !out_item.ready && v[NST-2] |=> v[NST-1] && v[NST-2])
    else $error("item lost while the output stalls");

endmodule

`default_nettype wire
